>>> hdl/frlpm_pkg.sv
// Shared types and constants for the flash ring log pointer manager.
`default_nettype none

package frlpm_pkg;

   // default geometry
   localparam int unsigned DEF_SECTOR_COUNT     = 4;
   localparam int unsigned DEF_SLOTS_PER_SECTOR = 12;
   localparam int unsigned DEF_SLOT_BYTES       = 320;
   localparam int unsigned DEF_SECTOR_BYTES     = 4096;
   localparam int unsigned DEF_FIRST_SECTOR     = 64;

   localparam int unsigned ADDR_W      = 24;
   localparam int unsigned COUNT_W     = 6;
   localparam int unsigned SECNUM_W    = 13;
   localparam int unsigned PROD_W      = 32;
   localparam int unsigned REQ_TDATA_W = 64;
   localparam int unsigned RSP_TDATA_W = 56;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [15:0] MAX_LENGTH = 16'd1023;
   localparam logic [31:0] BLANK_TIME = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      OP_APPEND     = 3'd0,
      OP_LOCATE     = 3'd1,
      OP_SCAN_BEGIN = 3'd2,
      OP_SCAN_SLOT  = 3'd3,
      OP_SCAN_END   = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      RSP_OK            = 3'd0,
      RSP_REJECTED      = 3'd1,
      RSP_WRITE_FAILED  = 3'd2,
      RSP_NOT_FOUND     = 3'd3,
      RSP_SCAN_ACCEPTED = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_APPEND,
      CMD_LOCATE,
      CMD_SCAN_BEGIN,
      CMD_SCAN_SLOT,
      CMD_SCAN_END
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         len_ok;
      logic         write_ok;
      logic         slot_blank;
      logic         marked;
      logic [7:0]   back_index;
      logic [31:0]  slot_time;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_FORM
   } bk_state_type;

endpackage

`default_nettype wire

>>> hdl/frlpm_front.sv
// Front end: accepts request beats and decodes them into queue commands.
`default_nettype none

module frlpm_front (
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // bits from 0: record_length[15:0], back_index[23:16], slot_time[55:24],
   // region_blank[56], header_verified[57], last_slot_marked[58], zero[63:59]
   input  logic [frlpm_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // opcode[2:0]
   input  logic [2:0]                          req_tuser,
   output logic                                q_push,
   output frlpm_pkg::cmd_type                  q_cmd,
   input  logic                                q_full
);
   import frlpm_pkg::*;

   logic [15:0] record_length;
   logic        region_blank;
   logic        header_verified;

   assign record_length   = req_tdata[15:0];
   assign region_blank    = req_tdata[56];
   assign header_verified = req_tdata[57];

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      unique case (op_type'(req_tuser))
         OP_APPEND:     q_cmd.kind = CMD_APPEND;
         OP_LOCATE:     q_cmd.kind = CMD_LOCATE;
         OP_SCAN_BEGIN: q_cmd.kind = CMD_SCAN_BEGIN;
         OP_SCAN_SLOT:  q_cmd.kind = CMD_SCAN_SLOT;
         OP_SCAN_END:   q_cmd.kind = CMD_SCAN_END;
         default:       q_cmd.kind = CMD_NOP;
      endcase
      q_cmd.len_ok     = (record_length <= MAX_LENGTH);
      q_cmd.write_ok   = region_blank && header_verified;
      q_cmd.slot_blank = (req_tdata[55:24] == BLANK_TIME);
      q_cmd.marked     = req_tdata[58];
      q_cmd.back_index = req_tdata[23:16];
      q_cmd.slot_time  = req_tdata[55:24];
   end

endmodule

`default_nettype wire

>>> hdl/frlpm_queue.sv
// Short command queue between the decode front and the execution back end.
`default_nettype none

module frlpm_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  frlpm_pkg::cmd_type push_cmd,
   output logic               full,
   input  logic               pop,
   output frlpm_pkg::cmd_type pop_cmd,
   output logic               empty
);
   import frlpm_pkg::*;

   localparam int unsigned QPTR_W = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/frlpm_back.sv
// Back end: pointer state, command execution, slot divider and result register.
`default_nettype none

module frlpm_back #(
   parameter int unsigned SECTOR_COUNT     = frlpm_pkg::DEF_SECTOR_COUNT,
   parameter int unsigned SLOTS_PER_SECTOR = frlpm_pkg::DEF_SLOTS_PER_SECTOR,
   parameter int unsigned SLOT_BYTES       = frlpm_pkg::DEF_SLOT_BYTES,
   parameter int unsigned SECTOR_BYTES     = frlpm_pkg::DEF_SECTOR_BYTES,
   parameter int unsigned FIRST_SECTOR     = frlpm_pkg::DEF_FIRST_SECTOR
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_empty,
   input  frlpm_pkg::cmd_type                q_cmd,
   output logic                              q_pop,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output frlpm_pkg::status_type             rsp_status,
   output logic [frlpm_pkg::ADDR_W-1:0]      rsp_slot_address,
   output logic                              rsp_erase_request,
   output logic [frlpm_pkg::ADDR_W-1:0]      rsp_erase_address,
   output logic [frlpm_pkg::COUNT_W-1:0]     rsp_record_count,
   output logic                              rsp_wrapped
);
   import frlpm_pkg::*;

   localparam int unsigned TOTAL_SLOTS = SECTOR_COUNT * SLOTS_PER_SECTOR;
   localparam int unsigned SLOT_W      = $clog2(SLOTS_PER_SECTOR + 1);
   localparam int unsigned SEC_W       = $clog2(SECTOR_COUNT);
   localparam int unsigned SCAN_SEC_W  = $clog2(SECTOR_COUNT + 1);
   localparam int unsigned POS_W       = $clog2(TOTAL_SLOTS + 1);
   localparam int unsigned LW          = ((POS_W > 8) ? POS_W : 8) + 1;
   // reciprocal of the slot count, exact for every position up to TOTAL_SLOTS
   localparam int unsigned DIV_SHIFT   = POS_W + $clog2(SLOTS_PER_SECTOR);
   localparam int unsigned DIV_MUL     =
      (2 ** DIV_SHIFT + SLOTS_PER_SECTOR - 1) / SLOTS_PER_SECTOR;
   localparam int unsigned DPROD_W     = POS_W + DIV_SHIFT + 1;

   localparam logic [SLOT_W-1:0]     SPS_S    = SLOT_W'(SLOTS_PER_SECTOR);
   localparam logic [SEC_W-1:0]      LAST_SEC = SEC_W'(SECTOR_COUNT - 1);
   localparam logic [SCAN_SEC_W-1:0] SC_S     = SCAN_SEC_W'(SECTOR_COUNT);
   localparam logic [POS_W-1:0]      WRAP_BASE =
      POS_W'((SECTOR_COUNT - 1) * SLOTS_PER_SECTOR);

   bk_state_type state_ff, state_in;

   // pointer and recovery state
   logic [SLOT_W-1:0]     write_slot_ff, write_slot_in;
   logic [SEC_W-1:0]      write_sector_ff, write_sector_in;
   logic                  wrap_ff, wrap_in;
   logic [SLOT_W-1:0]     scan_slot_ff, scan_slot_in;
   logic [SCAN_SEC_W-1:0] scan_sector_ff, scan_sector_in;
   logic                  scan_stopped_ff, scan_stopped_in;
   logic [31:0]           newest_ff, newest_in;

   // pending result, turned into addresses in the form cycle
   // (a locate at the end of the last sector points one sector past it)
   status_type            res_status_ff, res_status_in;
   logic                  res_has_addr_ff, res_has_addr_in;
   logic [SCAN_SEC_W-1:0] res_sec_ff, res_sec_in;
   logic [SLOT_W-1:0]     res_slot_ff, res_slot_in;
   logic                  res_ereq_ff, res_ereq_in;
   logic [SEC_W-1:0]      res_esec_ff, res_esec_in;

   // locate target position, split into sector and slot in the divide cycle
   logic [POS_W-1:0]      rem_ff, rem_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff;
   logic [ADDR_W-1:0]     rsp_addr_ff;
   logic                  rsp_ereq_ff;
   logic [ADDR_W-1:0]     rsp_eaddr_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;
   logic                  rsp_wrapped_ff;

   logic                  exec;
   logic                  form;
   logic                  dividing;

   logic [LW-1:0]         pos_cur;
   logic [LW-1:0]         back_w;
   logic [LW-1:0]         loc_target;
   logic                  loc_miss;

   logic [SEC_W-1:0]      next_sec;
   logic [DPROD_W-1:0]    div_prod;
   logic [SCAN_SEC_W-1:0] div_sec;
   logic [POS_W-1:0]      div_slot;

   logic [PROD_W-1:0]     slot_prod;
   logic [PROD_W-1:0]     sec_prod;
   logic [PROD_W-1:0]     esec_prod;
   logic [PROD_W-1:0]     addr_sum;
   logic [POS_W-1:0]      count_full;

   // ---------------- control
   assign exec = (state_ff == BK_IDLE) && !q_empty && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (exec) begin
               state_in = (q_cmd.kind == CMD_LOCATE && !loc_miss) ? BK_DIVIDE : BK_FORM;
            end
         end
         BK_DIVIDE: state_in = BK_FORM;
         BK_FORM: state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop    = 1'b0;
      form     = 1'b0;
      dividing = 1'b0;
      unique case (state_ff)
         BK_IDLE:   q_pop    = exec;
         BK_DIVIDE: dividing = 1'b1;
         BK_FORM:   form     = 1'b1;
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // ---------------- locate position
   always_comb begin
      pos_cur  = LW'(write_sector_ff) * LW'(SLOTS_PER_SECTOR) + LW'(write_slot_ff);
      back_w   = LW'(q_cmd.back_index);
      loc_miss = (back_w >= LW'(TOTAL_SLOTS)) || ((back_w > pos_cur) && !wrap_ff);
      if (back_w > pos_cur) begin
         loc_target = pos_cur + LW'(TOTAL_SLOTS) - back_w;
      end else begin
         loc_target = pos_cur - back_w;
      end
   end

   assign next_sec = (write_sector_ff == LAST_SEC) ? '0 : write_sector_ff + 1'b1;
   assign div_prod = DPROD_W'(rem_ff) * DPROD_W'(DIV_MUL);
   assign div_sec  = SCAN_SEC_W'(div_prod >> DIV_SHIFT);
   assign div_slot = rem_ff - POS_W'(div_sec) * POS_W'(SLOTS_PER_SECTOR);

   // ---------------- execution
   always_comb begin
      write_slot_in   = write_slot_ff;
      write_sector_in = write_sector_ff;
      wrap_in         = wrap_ff;
      scan_slot_in    = scan_slot_ff;
      scan_sector_in  = scan_sector_ff;
      scan_stopped_in = scan_stopped_ff;
      newest_in       = newest_ff;
      res_status_in   = res_status_ff;
      res_has_addr_in = res_has_addr_ff;
      res_sec_in      = res_sec_ff;
      res_slot_in     = res_slot_ff;
      res_ereq_in     = res_ereq_ff;
      res_esec_in     = res_esec_ff;
      rem_in          = rem_ff;

      if (exec) begin
         res_status_in   = RSP_OK;
         res_has_addr_in = 1'b0;
         res_ereq_in     = 1'b0;
         case (q_cmd.kind)
            CMD_APPEND: begin
               if (!q_cmd.len_ok || write_slot_ff >= SPS_S) begin
                  res_status_in = RSP_REJECTED;
               end else begin
                  res_has_addr_in = 1'b1;
                  res_sec_in      = SCAN_SEC_W'(write_sector_ff);
                  res_slot_in     = write_slot_ff;
                  if (!q_cmd.write_ok) begin
                     // restart the sector from its first slot
                     write_slot_in = '0;
                     res_ereq_in   = 1'b1;
                     res_esec_in   = write_sector_ff;
                     res_status_in = RSP_WRITE_FAILED;
                  end else if (write_slot_ff + 1'b1 >= SPS_S) begin
                     write_slot_in   = '0;
                     write_sector_in = next_sec;
                     res_ereq_in     = 1'b1;
                     res_esec_in     = next_sec;
                     if (write_sector_ff == LAST_SEC) begin
                        wrap_in = 1'b1;
                     end
                  end else begin
                     write_slot_in = write_slot_ff + 1'b1;
                  end
               end
            end
            CMD_LOCATE: begin
               if (loc_miss) begin
                  res_status_in = RSP_NOT_FOUND;
               end else begin
                  res_has_addr_in = 1'b1;
                  rem_in          = POS_W'(loc_target);
               end
            end
            CMD_SCAN_BEGIN: begin
               write_slot_in   = '0;
               write_sector_in = '0;
               wrap_in         = 1'b0;
               scan_slot_in    = '0;
               scan_sector_in  = '0;
               scan_stopped_in = 1'b0;
               newest_in       = '0;
               res_status_in   = RSP_SCAN_ACCEPTED;
            end
            CMD_SCAN_SLOT: begin
               res_status_in = RSP_SCAN_ACCEPTED;
               if (scan_sector_ff < SC_S) begin
                  if (!scan_stopped_ff) begin
                     if (q_cmd.slot_blank) begin
                        scan_stopped_in = 1'b1;
                     end else if (q_cmd.slot_time > newest_ff) begin
                        newest_in       = q_cmd.slot_time;
                        write_slot_in   = scan_slot_ff + 1'b1;
                        write_sector_in = SEC_W'(scan_sector_ff);
                     end
                  end
                  if (scan_slot_ff + 1'b1 >= SPS_S) begin
                     scan_slot_in    = '0;
                     scan_sector_in  = scan_sector_ff + 1'b1;
                     scan_stopped_in = 1'b0;
                  end else begin
                     scan_slot_in = scan_slot_ff + 1'b1;
                  end
               end
            end
            CMD_SCAN_END: begin
               res_status_in = RSP_SCAN_ACCEPTED;
               if (write_slot_ff >= SPS_S) begin
                  write_slot_in   = '0;
                  write_sector_in = next_sec;
                  res_ereq_in     = 1'b1;
                  res_esec_in     = next_sec;
               end
               if (q_cmd.marked) begin
                  wrap_in = 1'b1;
               end
            end
            default: begin
               res_status_in = RSP_OK;
            end
         endcase
      end

      if (dividing) begin
         res_sec_in  = div_sec;
         res_slot_in = SLOT_W'(div_slot);
      end
   end

   // ---------------- result formation
   always_comb begin
      slot_prod  = PROD_W'(res_slot_ff) * PROD_W'(SLOT_BYTES);
      sec_prod   = PROD_W'(SECNUM_W'(FIRST_SECTOR) + SECNUM_W'(res_sec_ff))
                   * PROD_W'(SECTOR_BYTES);
      esec_prod  = PROD_W'(SECNUM_W'(FIRST_SECTOR) + SECNUM_W'(res_esec_ff))
                   * PROD_W'(SECTOR_BYTES);
      addr_sum   = sec_prod + slot_prod;
      if (wrap_ff) begin
         count_full = WRAP_BASE + POS_W'(write_slot_ff);
      end else begin
         count_full = POS_W'(write_sector_ff) * POS_W'(SLOTS_PER_SECTOR)
                      + POS_W'(write_slot_ff);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (form) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (form) begin
         rsp_status_ff  <= res_status_ff;
         rsp_addr_ff    <= res_has_addr_ff ? addr_sum[ADDR_W-1:0] : '0;
         rsp_ereq_ff    <= res_ereq_ff;
         rsp_eaddr_ff   <= res_ereq_ff ? esec_prod[ADDR_W-1:0] : '0;
         rsp_count_ff   <= COUNT_W'(count_full);
         rsp_wrapped_ff <= wrap_ff;
      end
   end

   always_ff @(posedge clock) begin
      res_status_ff   <= res_status_in;
      res_has_addr_ff <= res_has_addr_in;
      res_sec_ff      <= res_sec_in;
      res_slot_ff     <= res_slot_in;
      res_ereq_ff     <= res_ereq_in;
      res_esec_ff     <= res_esec_in;
      rem_ff          <= rem_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= BK_IDLE;
         write_slot_ff   <= '0;
         write_sector_ff <= '0;
         wrap_ff         <= 1'b0;
         scan_slot_ff    <= '0;
         scan_sector_ff  <= '0;
         scan_stopped_ff <= 1'b0;
         newest_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         write_slot_ff   <= write_slot_in;
         write_sector_ff <= write_sector_in;
         wrap_ff         <= wrap_in;
         scan_slot_ff    <= scan_slot_in;
         scan_sector_ff  <= scan_sector_in;
         scan_stopped_ff <= scan_stopped_in;
         newest_ff       <= newest_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot_address  = rsp_addr_ff;
   assign rsp_erase_request = rsp_ereq_ff;
   assign rsp_erase_address = rsp_eaddr_ff;
   assign rsp_record_count  = rsp_count_ff;
   assign rsp_wrapped       = rsp_wrapped_ff;

   // ---------------- checks
   a_write_slot_range: assert property (@(posedge clock) disable iff (reset)
      write_slot_ff <= SPS_S)
      else $error("write slot beyond end of sector");

   a_write_sector_range: assert property (@(posedge clock) disable iff (reset)
      write_sector_ff <= LAST_SEC)
      else $error("write sector outside ring");

   a_scan_sector_range: assert property (@(posedge clock) disable iff (reset)
      scan_sector_ff <= SC_S)
      else $error("scan sector ran past end");

   a_rsp_from_form: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == BK_FORM))
      else $error("result raised outside form cycle");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_FORM && $past(state_ff == BK_DIVIDE))
      |-> (res_slot_ff < SPS_S))
      else $error("divider remainder not below slots per sector");

endmodule

`default_nettype wire

>>> hdl/flash_ring_log_pointer_manager_core.sv
// Flow: a beat is written into the queue, then executed and formed into the result
// register by the back end; a locate that hits also passes the divide state to split
// its position into sector and slot. The back end finishes one command before the next
// and stalls on an unaccepted result; a two-entry queue decouples the request side.
// Reset: synchronous, active high; clears write and scan pointers, the wrap
// flag, the command queue and any pending result.
// Top level of the flash ring log pointer manager.
`default_nettype none

module flash_ring_log_pointer_manager_core #(
   parameter int unsigned SECTOR_COUNT     = frlpm_pkg::DEF_SECTOR_COUNT,
   parameter int unsigned SLOTS_PER_SECTOR = frlpm_pkg::DEF_SLOTS_PER_SECTOR,
   parameter int unsigned SLOT_BYTES       = frlpm_pkg::DEF_SLOT_BYTES,
   parameter int unsigned SECTOR_BYTES     = frlpm_pkg::DEF_SECTOR_BYTES,
   parameter int unsigned FIRST_SECTOR     = frlpm_pkg::DEF_FIRST_SECTOR
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // bits from 0: record_length[15:0], back_index[23:16], slot_time[55:24],
   // region_blank[56], header_verified[57], last_slot_marked[58], zero[63:59]
   input  logic [frlpm_pkg::REQ_TDATA_W-1:0] req_tdata,
   // opcode[2:0]
   input  logic [2:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // bits from 0: slot_address[23:0], erase_request[24], erase_address[48:25],
   // record_count[54:49], wrapped[55]
   output logic [frlpm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // status[2:0]
   output logic [2:0]                        rsp_tuser
);
   import frlpm_pkg::*;

   logic               q_push;
   logic               q_full;
   logic               q_pop;
   logic               q_empty;
   cmd_type            push_cmd;
   cmd_type            pop_cmd;

   status_type         status;
   logic [ADDR_W-1:0]  slot_address;
   logic               erase_request;
   logic [ADDR_W-1:0]  erase_address;
   logic [COUNT_W-1:0] record_count;
   logic               wrapped;

   frlpm_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_push     (q_push),
      .q_cmd      (push_cmd),
      .q_full     (q_full)
   );

   frlpm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .empty    (q_empty)
   );

   frlpm_back #(
      .SECTOR_COUNT     (SECTOR_COUNT),
      .SLOTS_PER_SECTOR (SLOTS_PER_SECTOR),
      .SLOT_BYTES       (SLOT_BYTES),
      .SECTOR_BYTES     (SECTOR_BYTES),
      .FIRST_SECTOR     (FIRST_SECTOR)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_cmd             (pop_cmd),
      .q_pop             (q_pop),
      .rsp_ready         (rsp_tready),
      .rsp_valid         (rsp_tvalid),
      .rsp_status        (status),
      .rsp_slot_address  (slot_address),
      .rsp_erase_request (erase_request),
      .rsp_erase_address (erase_address),
      .rsp_record_count  (record_count),
      .rsp_wrapped       (wrapped)
   );

   assign rsp_tdata = {wrapped, record_count, erase_address, erase_request, slot_address};
   assign rsp_tuser = status;

endmodule

`default_nettype wire
